// ===== sv/assert_macros.svh =====
// assertion macros shared by the parser modules
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define AIP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("aip assertion failed");

// consequent holds in the cycle after the antecedent
`define AIP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aip assertion failed");

`endif

// ===== sv/aip_pkg.sv =====
// shared types, codes and helpers for the ascii integer parser
// no dependencies
package aip_pkg;

   localparam int unsigned ValueWidth = 64;

   // number_mode codes
   localparam logic [1:0] MODE_UDEC = 2'd0;
   localparam logic [1:0] MODE_SDEC = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;

   // width_code codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_NUMBER_MODE = 2'd0;
   localparam logic [1:0] CSR_WIDTH_CODE  = 2'd1;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic       is_end;
      logic       is_dec;
      logic       is_hex;
      logic       is_plus;
      logic       is_minus;
      logic       is_x;
      logic [3:0] nib;
   } char_class_type;

   function automatic logic [ValueWidth-1:0] width_umax(input logic [1:0] code);
      logic [ValueWidth-1:0] umax;
      case (code)
         WIDTH_8:  umax = 64'h0000_0000_0000_00FF;
         WIDTH_16: umax = 64'h0000_0000_0000_FFFF;
         WIDTH_32: umax = 64'h0000_0000_FFFF_FFFF;
         WIDTH_64: umax = 64'hFFFF_FFFF_FFFF_FFFF;
         default:  umax = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return umax;
   endfunction

endpackage

// ===== sv/aip_front.sv =====
// front end: takes text bytes and classifies each one for the back end
// depends on aip_pkg
module aip_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_text_byte,
   input  logic                    q_full,
   output logic                    q_push,
   output aip_pkg::char_class_type q_class
);
   import aip_pkg::*;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_class          = '0;
      q_class.is_end   = (req_text_byte == CHAR_NUL);
      q_class.is_plus  = (req_text_byte == CHAR_PLUS);
      q_class.is_minus = (req_text_byte == CHAR_MINUS);
      q_class.is_x     = (req_text_byte == CHAR_X_LO) || (req_text_byte == CHAR_X_UP);
      if (req_text_byte inside {[8'h30:8'h39]}) begin
         q_class.is_dec = 1'b1;
         q_class.is_hex = 1'b1;
         q_class.nib    = req_text_byte[3:0];
      end else if (req_text_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         // letter a..f in either case: low three bits 1..6
         q_class.is_hex = 1'b1;
         q_class.nib    = 4'(req_text_byte[2:0] + 3'd1) + 4'd8;
      end
   end

endmodule

// ===== sv/aip_queue.sv =====
// two-entry queue of classified bytes between front and back ends
// depends on aip_pkg and assert_macros.svh
module aip_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  aip_pkg::char_class_type push_class,
   output logic                    full,
   input  logic                    pop,
   output logic                    q_valid,
   output aip_pkg::char_class_type q_class
);
   import aip_pkg::*;
   `include "assert_macros.svh"

   char_class_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_class = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_class;
      end
   end

   `AIP_ASSERT(a_count_bound, count_ff != 2'd3)
   `AIP_ASSERT(a_pop_nonempty, !pop || count_ff != 2'd0)

endmodule

// ===== sv/aip_back.sv =====
// back end: runs the parse state on each classified byte and holds the result
// depends on aip_pkg and assert_macros.svh
module aip_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  aip_pkg::char_class_type q_class,
   output logic                    q_pop,
   input  logic [1:0]              number_mode,
   input  logic [1:0]              width_code,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_value,
   output logic                    rsp_ok
);
   import aip_pkg::*;
   `include "assert_macros.svh"

   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [1:0]  chars_ff, chars_in;
   logic        digit_ff, digit_in;
   logic        failed_ff, failed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        pop_end;
   logic [63:0] dec_limit;
   logic [67:0] dec_wide;
   logic [63:0] umax;
   logic [63:0] sdec_lim;
   logic        end_ok;
   logic [63:0] end_value;

   assign q_pop   = q_valid && (!q_class.is_end || !rsp_valid_ff || rsp_ready);
   assign pop_end = q_pop && q_class.is_end;

   // times ten as shift-add, kept 68 bits wide so overflow is exact
   assign dec_limit = (number_mode == MODE_SDEC) ? {neg_ff, {63{!neg_ff}}} : '1;
   assign dec_wide  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {64'd0, q_class.nib};

   assign umax     = width_umax(width_code);
   assign sdec_lim = {1'b0, umax[63:1]} + {63'd0, neg_ff};

   always_comb begin
      end_ok    = !failed_ff && (chars_ff != 2'd0);
      end_value = acc_ff;
      case (number_mode)
         MODE_SDEC: begin
            end_ok    = end_ok && (acc_ff <= sdec_lim);
            end_value = neg_ff ? (64'd0 - acc_ff) : acc_ff;
         end
         MODE_UDEC, MODE_HEX: begin
            end_ok = end_ok && digit_ff && (acc_ff <= umax);
         end
         default: begin
            end_ok = 1'b0;
         end
      endcase
      if (!end_ok) begin
         end_value = '0;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      chars_in  = chars_ff;
      digit_in  = digit_ff;
      failed_in = failed_ff;
      if (pop_end) begin
         acc_in    = '0;
         neg_in    = 1'b0;
         chars_in  = 2'd0;
         digit_in  = 1'b0;
         failed_in = 1'b0;
      end else if (q_pop) begin
         chars_in = (chars_ff == 2'd3) ? chars_ff : chars_ff + 2'd1;
         if (!failed_ff) begin
            case (number_mode)
               MODE_UDEC, MODE_SDEC: begin
                  if (number_mode == MODE_SDEC && chars_ff == 2'd0 &&
                      (q_class.is_plus || q_class.is_minus)) begin
                     neg_in = q_class.is_minus;
                  end else if (!q_class.is_dec || dec_wide > {4'd0, dec_limit}) begin
                     failed_in = 1'b1;
                  end else begin
                     acc_in   = dec_wide[63:0];
                     digit_in = 1'b1;
                  end
               end
               MODE_HEX: begin
                  // 0x prefix only straight after a leading zero
                  if (chars_ff == 2'd1 && q_class.is_x && digit_ff && acc_ff == '0) begin
                     digit_in = 1'b0;
                  end else if (!q_class.is_hex || acc_ff[63:60] != 4'd0) begin
                     failed_in = 1'b1;
                  end else begin
                     acc_in   = {acc_ff[59:0], q_class.nib};
                     digit_in = 1'b1;
                  end
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (pop_end) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = end_value;
         rsp_ok_in    = end_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         chars_ff     <= 2'd0;
         digit_ff     <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         chars_ff     <= chars_in;
         digit_ff     <= digit_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_ok    = rsp_ok_ff;

   `AIP_ASSERT_NEXT(a_clear_after_end, pop_end,
      acc_ff == '0 && chars_ff == 2'd0 && !failed_ff && !digit_ff && !neg_ff)
   `AIP_ASSERT(a_fail_is_zero, !rsp_valid_ff || rsp_ok_ff || rsp_value_ff == '0)

endmodule

// ===== sv/ascii_integer_parser.sv =====
// ascii integer parser: text bytes in on req_, one result per zero byte on rsp_.
// Each req_ item is one character; a zero byte ends the text and gives one
// rsp_ item with the parsed 64-bit value and an ok flag (value zero when not ok).
// csr_ writes set number_mode (index 0) and width_code (index 1); other indexes
// are ignored. csr_ready is always high; write only while the parser is idle.
// With the queue ahead of it empty, a zero byte is first written into the queue,
// then popped by the back end into the result register that drives rsp_valid.
// Throughput: one byte per cycle unless a zero byte stalls behind a held result;
// the times-ten shift-add and overflow compare in the back end are combinational.
// A two-entry queue sits between the byte classifier and the back end; the
// result register lets bytes of the next text keep flowing while a result waits.
// When rsp_ready is low with a result held, only a second zero byte stalls;
// the queue then fills and req_ready drops.
// Reset (synchronous, active high) clears the parse state and queue, sets
// number_mode to unsigned decimal and width_code to 64 bits.
// depends on aip_pkg, aip_front, aip_queue, aip_back
module ascii_integer_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata
);
   import aip_pkg::*;

   logic [1:0]     number_mode_ff, number_mode_in;
   logic [1:0]     width_code_ff, width_code_in;
   logic           q_full;
   logic           q_push;
   char_class_type push_class;
   logic           q_valid;
   char_class_type q_class;
   logic           q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      number_mode_in = number_mode_ff;
      width_code_in  = width_code_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUMBER_MODE: number_mode_in = csr_wdata;
            CSR_WIDTH_CODE:  width_code_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_mode_ff <= MODE_UDEC;
         width_code_ff  <= WIDTH_64;
      end else begin
         number_mode_ff <= number_mode_in;
         width_code_ff  <= width_code_in;
      end
   end

   aip_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_class       (push_class)
   );

   aip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_class (push_class),
      .full       (q_full),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .q_class    (q_class)
   );

   aip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_class     (q_class),
      .q_pop       (q_pop),
      .number_mode (number_mode_ff),
      .width_code  (width_code_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_ok      (rsp_ok)
   );

endmodule
